/* hw/rtl/drrc_pkg.sv */
// Shared types and constants for the decimal rescale, round and clamp block.
// Holds the pipeline stage record, rounding mode codes and power-of-ten tables.
// Depends on nothing.
package drrc_pkg;

  localparam int DATA_W   = 64;
  localparam int DIV_STG  = 64;
  localparam int MUL_STG  = 19;
  localparam int MAX_DIG  = 18;
  localparam int MAX_DOWN = 19;

  localparam logic [1:0] RM_ZERO = 2'd0;
  localparam logic [1:0] RM_UP   = 2'd1;
  localparam logic [1:0] RM_DOWN = 2'd2;

  typedef struct packed {
    logic              neg;
    logic              up;
    logic              down;
    logic              ovf;
    logic              sat;
    logic [1:0]        mode;
    logic [4:0]        dsh;
    logic [4:0]        prec;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] rem;
  } stage_t;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic              sat_hit;
    logic              inexact;
    logic [4:0]        prec;
    logic [DATA_W-1:0] mag;
  } rnd_t;

  // Ten to the power n, n up to 19.
  function automatic logic [DATA_W-1:0] pow10(input logic [4:0] n);
    logic [DATA_W-1:0] p;
    p = 64'd1;
    unique case (n)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd10000000000000000000;
    endcase
    return p;
  endfunction

  // Largest magnitude with n decimal digits, n up to 18.
  function automatic logic [DATA_W-1:0] max_dig(input logic [4:0] n);
    return pow10(n) - 64'd1;
  endfunction

endpackage

/* hw/rtl/decimal_rescale_round_clamp_top.sv */
// Top level of the decimal rescale, round and clamp block.
// Uses drrc_pkg for the stage records, rounding codes and power-of-ten tables.
// Fully pipelined: long division stages, multiply-by-ten stages, round and clamp.

// The block accepts one word per clock while the output register is empty or
// being taken, and returns one result word per word, in order. The word
// passes through 86 registers: the input register, which is loaded at the
// accepting edge, a restoring divider by the power of ten that settles one
// quotient bit per stage over 64 stages, 19 multiply-by-ten stages for
// scale-up, one rounding stage and one clamping output stage. The long
// division sets most of that length. Every stage holds a valid bit and the
// whole pipe advances together whenever the output register is empty or
// being taken, so a stall on the output holds every word in place.
module decimal_rescale_round_clamp_top #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[63:0], src_scale[68:64], dst_scale[73:69], out_precision[78:74],
  // round_mode[80:79], saturate_on_inexact[81], zero fill above
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result[63:0], inexact[64], clamped[65], zero fill above
  output logic [71:0] out_tdata
);

  localparam int DW  = drrc_pkg::DATA_W;
  localparam int ND  = drrc_pkg::DIV_STG;
  localparam int NM  = drrc_pkg::MUL_STG;
  localparam int NST = 1 + ND + NM;

  // Whole pipe moves when the output register can take a word.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  drrc_pkg::stage_t st_r  [NST];
  drrc_pkg::stage_t st_nxt[NST];
  logic [NST-1:0]   vld_r;

  drrc_pkg::rnd_t rnd_r, rnd_nxt;
  logic           rnd_vld_r;

  logic [DW-1:0]  res_r, res_nxt;
  logic           inx_r, inx_nxt;
  logic           clp_r, clp_nxt;
  logic           out_vld_r;

  // Input decode: sign-extend the low VALUE_BITS bits, split sign and magnitude.
  logic [DW-1:0] raw_ext;
  logic [4:0]    isc, osc, sdiff;
  logic [4:0]    prc;

  always_comb begin
    for (int i = 0; i < DW; i++) begin
      raw_ext[i] = (i < VALUE_BITS) ? in_tdata[i] : in_tdata[VALUE_BITS-1];
    end
    isc   = in_tdata[68:64];
    osc   = in_tdata[73:69];
    prc   = in_tdata[78:74];
    sdiff = (osc > isc) ? (osc - isc) : (isc - osc);
    st_nxt[0].neg  = raw_ext[DW-1];
    st_nxt[0].mag  = raw_ext[DW-1] ? (~raw_ext + 64'd1) : raw_ext;
    st_nxt[0].up   = osc > isc;
    st_nxt[0].down = isc > osc;
    st_nxt[0].ovf  = 1'b0;
    st_nxt[0].sat  = in_tdata[81];
    st_nxt[0].mode = in_tdata[80:79];
    st_nxt[0].dsh  = ((isc > osc) && (sdiff > 5'(drrc_pkg::MAX_DOWN))) ?
                     5'(drrc_pkg::MAX_DOWN) : sdiff;
    st_nxt[0].prec = (prc > 5'(drrc_pkg::MAX_DIG)) ? 5'(drrc_pkg::MAX_DIG) : prc;
    st_nxt[0].rem  = '0;
  end

  // Restoring division by ten to the scale difference, one quotient bit a stage.
  // The magnitude register shifts the dividend out and the quotient in.
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [DW:0] rn, dv, df;
    logic        ge;
    always_comb begin
      rn = {st_r[k].rem, st_r[k].mag[DW-1]};
      dv = {1'b0, drrc_pkg::pow10(st_r[k].dsh)};
      df = rn - dv;
      ge = rn >= dv;
      st_nxt[k+1] = st_r[k];
      if (st_r[k].down) begin
        st_nxt[k+1].rem = ge ? df[DW-1:0] : rn[DW-1:0];
        st_nxt[k+1].mag = {st_r[k].mag[DW-2:0], ge};
      end
    end
  end

  // Scale up by one factor of ten per stage; overflow is sticky and freezes mag.
  for (genvar m = 0; m < NM; m++) begin : g_mul
    localparam int SI = 1 + ND + m - 1;
    logic [DW+3:0] prod, lim;
    always_comb begin
      prod = ({4'b0, st_r[SI].mag} << 3) + ({4'b0, st_r[SI].mag} << 1);
      lim  = (68'd1 << (VALUE_BITS - 1)) - {67'd0, !st_r[SI].neg};
      st_nxt[SI+1] = st_r[SI];
      if (st_r[SI].up && !st_r[SI].ovf && (5'(m) < st_r[SI].dsh)) begin
        if (prod > lim) begin
          st_nxt[SI+1].ovf = 1'b1;
        end else begin
          st_nxt[SI+1].mag = prod[DW-1:0];
        end
      end
    end
  end

  // Directed rounding of an inexact quotient.
  always_comb begin
    drrc_pkg::stage_t s;
    logic inx, inc;
    s   = st_r[NST-1];
    inx = s.down && (s.rem != '0);
    inc = inx && (((s.mode == drrc_pkg::RM_UP) && !s.neg) ||
                  ((s.mode == drrc_pkg::RM_DOWN) && s.neg));
    rnd_nxt.neg     = s.neg;
    rnd_nxt.ovf     = s.ovf;
    rnd_nxt.sat_hit = inx && s.sat;
    rnd_nxt.inexact = inx;
    rnd_nxt.prec    = s.prec;
    rnd_nxt.mag     = s.mag + {63'd0, inc};
  end

  // Precision clamp and sign restore.
  always_comb begin
    logic [DW-1:0] bnd, mg;
    logic          ng;
    bnd     = drrc_pkg::max_dig(rnd_r.prec);
    mg      = rnd_r.mag;
    ng      = rnd_r.neg;
    clp_nxt = 1'b0;
    priority if (rnd_r.ovf) begin
      mg      = bnd;
      clp_nxt = 1'b1;
    end else if (rnd_r.sat_hit) begin
      mg      = bnd;
      ng      = 1'b0;
      clp_nxt = 1'b1;
    end else if (rnd_r.mag > bnd) begin
      mg      = bnd;
      clp_nxt = 1'b1;
    end
    res_nxt = ng ? (~mg + 64'd1) : mg;
    inx_nxt = rnd_r.inexact;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rnd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NST-2:0], in_tvalid};
      rnd_vld_r <= vld_r[NST-1];
      out_vld_r <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= st_nxt[i];
      end
      rnd_r <= rnd_nxt;
      res_r <= res_nxt;
      inx_r <= inx_nxt;
      clp_r <= clp_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, clp_r, inx_r, res_r};

`ifndef SYNTHESIS
  logic div_rem_ok;
  assign div_rem_ok = st_r[ND].rem < drrc_pkg::pow10(st_r[ND].dsh);

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ND] && st_r[ND].down |-> div_rem_ok)
    else $error("division remainder not below divisor");

  a_ovf_only_up: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-1] && st_r[NST-1].ovf |-> st_r[NST-1].up)
    else $error("overflow flagged without scale-up");

  a_inexact_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_vld_r && rnd_r.inexact |-> !rnd_r.ovf)
    else $error("inexact and overflow together");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ($signed(res_r) <= 64'sd999999999999999999) &&
                  ($signed(res_r) >= -64'sd999999999999999999))
    else $error("result beyond eighteen digits");
`endif

endmodule
